[rtl/plob_pkg.sv]
package plob_pkg;

  // Default sizes handed to the top level
  localparam int DEF_BOOK_DEPTH = 64;
  localparam int DEF_FRAC_BITS  = 16;

  // Register reset value
  localparam logic [6:0] MAX_DEPTH_RESET = 7'd64;

  // Command codes carried in s_tuser
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_UPDATE = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;
  localparam logic [2:0] CMD_VWAP   = 3'd5;

  // Port widths
  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 360;

  // Saturation limits
  localparam logic [63:0] VWAP_MAX      = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] SLIP_POS_MAX  = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [63:0] SLIP_NEG_MAG  = 64'h0000_0100_0000_0000;
  localparam int          DIV_BASE_STEPS = 64;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_CLEAR,
    DP_SCAN_RD,
    DP_SCAN_NEXT,
    DP_OVERWRITE,
    DP_QUERY_HIT,
    DP_INS_SETUP,
    DP_SHIFT_RD,
    DP_SHIFT_WR,
    DP_PUT_NEW,
    DP_DEL_RD,
    DP_DEL_WR,
    DP_DEL_END,
    DP_WALK_RD,
    DP_WALK_MUL,
    DP_WALK_ACC,
    DP_VDIV_START,
    DP_VDIV_END,
    DP_SLIP_PREP,
    DP_SDIV_START,
    DP_SDIV_END,
    DP_FINISH_MOD,
    DP_OUT
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic is_mod;
    logic is_put;
    logic is_drop;
    logic is_query;
    logic is_vwap;
    logic is_clear;
    logic scan_end;
    logic match;
    logic stop_before;
    logic ins_ok;
    logic shift_more;
    logic del_more;
    logic walk_more;
    logic filled_zero;
    logic slip_needed;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/price_level_order_book_core.sv]
// Price-level order book core.
// Command words enter on the s_ channel (tuser: cmd, side; tdata: price,
// quantity). Every word yields exactly one result word on the m_ channel: a
// snapshot of best bid/ask, level counts and update count, plus the level
// quantity for a query and fill, vwap and slippage for a vwap command.
// The depth limit is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this. One
// word is processed at a time; s_tready is high only while idle.
// A vwap walks the levels, then divides for the vwap on the shared divider
// and divides again when slippage is computed.
// The result register holds a finished word while the next command is
// accepted and worked; a stalled m_tready then holds the core in its last
// state until the register frees, so nothing is lost.
// Reset (synchronous rst) empties both sides, zeroes the update count and
// sets the depth limit to 64. No memory clearing pass is needed.
module price_level_order_book_core #(
  parameter int BOOK_DEPTH = plob_pkg::DEF_BOOK_DEPTH,
  parameter int FRAC_BITS  = plob_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // [31:0] price, [63:32] quantity
  input  logic [plob_pkg::S_TDATA_W-1:0] s_tdata,
  // [2:0] cmd, [3] side
  input  logic [plob_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [31:0] best_bid_price, [63:32] best_bid_qty, [95:64] best_ask_price,
  // [127:96] best_ask_qty, [134:128] bid_levels, [141:135] ask_levels,
  // [205:142] update_count, [237:206] level_qty, [269:238] filled_qty,
  // [317:270] vwap_price, [358:318] slippage_pct, [359] zero
  output logic [plob_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_wr_en,
  input  logic [6:0]                     cfg_wr_data
);
  import plob_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  plob_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .op       (op)
  );

  plob_datapath #(
    .BOOK_DEPTH(BOOK_DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .status      (status),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

[rtl/plob_divider.sv]
module plob_divider #(
  parameter int FRAC_BITS = plob_pkg::DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        long_run,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);
  import plob_pkg::*;

  localparam int STEPS_LONG = DIV_BASE_STEPS + FRAC_BITS;
  localparam int SW         = $clog2(STEPS_LONG + 1);

  logic [SW-1:0] left;
  logic [63:0]   num;
  logic [31:0]   den;
  logic [31:0]   rem;
  logic [32:0]   rem2;
  logic          ge;

  // one restoring step: bring down the next dividend bit (zeros after 64)
  assign rem2 = {rem, num[63]};
  assign ge   = rem2 >= {1'b0, den};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
    end else if (start) begin
      busy <= 1'b1;
      left <= long_run ? SW'(STEPS_LONG) : SW'(DIV_BASE_STEPS);
    end else if (busy) begin
      left <= left - SW'(1);
      if (left == SW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // shift registers; quotient keeps its low 64 bits
  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      num      <= {num[62:0], 1'b0};
      rem      <= ge ? 32'(rem2 - {1'b0, den}) : rem2[31:0];
      quotient <= {quotient[62:0], ge};
    end
  end

endmodule

[rtl/plob_ctrl.sv]
module plob_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  plob_pkg::dp_status_t status,
  output plob_pkg::dp_op_t     op
);
  import plob_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE       = 18'h00001,
    ST_DISPATCH   = 18'h00002,
    ST_SCAN       = 18'h00004,
    ST_CHECK      = 18'h00008,
    ST_INS_SETUP  = 18'h00010,
    ST_SHIFT      = 18'h00020,
    ST_SHIFT_WR   = 18'h00040,
    ST_DEL        = 18'h00080,
    ST_DEL_WR     = 18'h00100,
    ST_WALK       = 18'h00200,
    ST_WALK_MUL   = 18'h00400,
    ST_WALK_ACC   = 18'h00800,
    ST_VDIV       = 18'h01000,
    ST_SLIP_PREP  = 18'h02000,
    ST_SDIV_START = 18'h04000,
    ST_SDIV       = 18'h08000,
    ST_FINISH     = 18'h10000,
    ST_DONE       = 18'h20000
  } state_t;

  state_t state, state_next;

  // no word is taken while reset is held
  assign s_tready = (state == ST_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing of one command word
  always_comb begin
    state_next = state;
    op         = DP_NONE;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          op         = DP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.is_clear) begin
          op         = DP_CLEAR;
          state_next = ST_DONE;
        end else if (status.is_put || status.is_drop || status.is_query) begin
          state_next = ST_SCAN;
        end else if (status.is_vwap) begin
          state_next = ST_WALK;
        end else begin
          state_next = ST_DONE;
        end
      end
      // linear search: read a level, then check it
      ST_SCAN: begin
        if (status.scan_end) begin
          state_next = status.is_put ? ST_INS_SETUP : ST_FINISH;
        end else begin
          op         = DP_SCAN_RD;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.match) begin
          if (status.is_put) begin
            op         = DP_OVERWRITE;
            state_next = ST_FINISH;
          end else if (status.is_drop) begin
            state_next = ST_DEL;
          end else begin
            op         = DP_QUERY_HIT;
            state_next = ST_FINISH;
          end
        end else if (status.stop_before) begin
          state_next = status.is_put ? ST_INS_SETUP : ST_FINISH;
        end else begin
          op         = DP_SCAN_NEXT;
          state_next = ST_SCAN;
        end
      end
      ST_INS_SETUP: begin
        if (status.ins_ok) begin
          op         = DP_INS_SETUP;
          state_next = ST_SHIFT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      // open a slot by moving worse levels down
      ST_SHIFT: begin
        if (status.shift_more) begin
          op         = DP_SHIFT_RD;
          state_next = ST_SHIFT_WR;
        end else begin
          op         = DP_PUT_NEW;
          state_next = ST_FINISH;
        end
      end
      ST_SHIFT_WR: begin
        op         = DP_SHIFT_WR;
        state_next = ST_SHIFT;
      end
      // close the gap by moving worse levels up
      ST_DEL: begin
        if (status.del_more) begin
          op         = DP_DEL_RD;
          state_next = ST_DEL_WR;
        end else begin
          op         = DP_DEL_END;
          state_next = ST_FINISH;
        end
      end
      ST_DEL_WR: begin
        op         = DP_DEL_WR;
        state_next = ST_DEL;
      end
      // vwap walk: read, multiply, accumulate
      ST_WALK: begin
        if (status.walk_more) begin
          op         = DP_WALK_RD;
          state_next = ST_WALK_MUL;
        end else if (status.filled_zero) begin
          state_next = ST_FINISH;
        end else begin
          op         = DP_VDIV_START;
          state_next = ST_VDIV;
        end
      end
      ST_WALK_MUL: begin
        op         = DP_WALK_MUL;
        state_next = ST_WALK_ACC;
      end
      ST_WALK_ACC: begin
        op         = DP_WALK_ACC;
        state_next = ST_WALK;
      end
      ST_VDIV: begin
        if (!status.div_busy) begin
          op         = DP_VDIV_END;
          state_next = ST_SLIP_PREP;
        end
      end
      ST_SLIP_PREP: begin
        if (status.slip_needed) begin
          op         = DP_SLIP_PREP;
          state_next = ST_SDIV_START;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SDIV_START: begin
        op         = DP_SDIV_START;
        state_next = ST_SDIV;
      end
      ST_SDIV: begin
        if (!status.div_busy) begin
          op         = DP_SDIV_END;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.is_mod) begin
          op = DP_FINISH_MOD;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          op         = DP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // an accepted word is always decoded on the next cycle
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_DISPATCH))
    else $error("accepted word not dispatched");

  // exactly one state bit is set
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state not one-hot");

  // while idle only a load may be issued
  a_idle_op: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> ((op == DP_NONE) || (op == DP_LOAD)))
    else $error("datapath operation while idle");
`endif

endmodule

[rtl/plob_datapath.sv]
module plob_datapath #(
  parameter int BOOK_DEPTH = plob_pkg::DEF_BOOK_DEPTH,
  parameter int FRAC_BITS  = plob_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  plob_pkg::dp_op_t                 op,
  output plob_pkg::dp_status_t             status,
  input  logic [plob_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [plob_pkg::S_TUSER_W-1:0]   s_tuser,
  input  logic                             cfg_wr_en,
  input  logic [6:0]                       cfg_wr_data,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [plob_pkg::M_TDATA_W-1:0]   m_tdata
);
  import plob_pkg::*;

  localparam int CW        = $clog2(BOOK_DEPTH + 1);
  localparam int AW        = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int LW        = (CW > 7) ? CW : 7;
  localparam int MEM_DEPTH = 2 ** (AW + 1);

  // level store: both sides, {price, qty} per entry
  logic [63:0] mem [MEM_DEPTH];

  // latched command word
  logic [2:0]  op_cmd;
  logic        op_side;
  logic [31:0] op_price;
  logic [31:0] op_qty;

  // book state
  logic [CW-1:0] cnt [2];
  logic [31:0]   best_p [2];
  logic [31:0]   best_q [2];
  logic [63:0]   seq;
  logic [6:0]    depth_cfg;

  // walk and scan state
  logic [CW-1:0] idx;
  logic [CW-1:0] k;
  logic [63:0]   rdata;
  logic [31:0]   remaining;
  logic [63:0]   total;
  logic [63:0]   prod;
  logic [31:0]   lvl;
  logic [31:0]   filled_r;
  logic [47:0]   vwap_r;
  logic [63:0]   v_full;
  logic [40:0]   slip_r;
  logic          neg;
  logic [63:0]   diff;

  logic          act_side;
  logic [CW-1:0] act_cnt;
  logic [31:0]   rd_price;
  logic [31:0]   rd_qty;
  logic [31:0]   fill;
  logic [31:0]   filled_now;
  logic [31:0]   ref_price;
  logic [63:0]   rfix;
  logic [63:0]   diff100;
  logic          is_bid;

  logic          rd_en;
  logic [CW-1:0] rd_idx;
  logic          we;
  logic [CW-1:0] wr_idx;
  logic [63:0]   wr_data;

  logic          div_start;
  logic          div_long;
  logic [63:0]   div_num;
  logic [31:0]   div_den;
  logic          div_busy;
  logic [63:0]   div_q;

  logic [LW-1:0] lim;
  logic [LW-1:0] bid_lv_w;
  logic [LW-1:0] ask_lv_w;
  logic [63:0]   slip_mag;

  // side being worked: vwap walks the opposite side
  assign act_side  = (op_cmd == CMD_VWAP) ? ~op_side : op_side;
  assign act_cnt   = cnt[act_side];
  assign is_bid    = ~op_side;
  assign rd_price  = rdata[63:32];
  assign rd_qty    = rdata[31:0];
  assign fill      = (rd_qty < remaining) ? rd_qty : remaining;
  assign filled_now = op_qty - remaining;
  assign ref_price = (act_cnt != '0) ? best_p[act_side] : 32'd0;
  assign rfix      = {32'd0, ref_price} << FRAC_BITS;
  assign diff100   = (diff << 6) + (diff << 5) + (diff << 2);

  // depth limit, min(depth_cfg, BOOK_DEPTH)
  assign lim = (LW'(depth_cfg) < LW'(BOOK_DEPTH)) ? LW'(depth_cfg) : LW'(BOOK_DEPTH);

  // status toward the controller
  always_comb begin
    status.is_mod      = (op_cmd == CMD_ADD) || (op_cmd == CMD_UPDATE) ||
                         (op_cmd == CMD_DELETE);
    status.is_put      = (op_cmd == CMD_ADD) || ((op_cmd == CMD_UPDATE) && (op_qty != '0));
    status.is_drop     = (op_cmd == CMD_DELETE) ||
                         ((op_cmd == CMD_UPDATE) && (op_qty == '0));
    status.is_query    = (op_cmd == CMD_QUERY);
    status.is_vwap     = (op_cmd == CMD_VWAP);
    status.is_clear    = (op_cmd == CMD_CLEAR);
    status.scan_end    = (idx >= act_cnt);
    status.match       = (rd_price == op_price);
    status.stop_before = is_bid ? (op_price > rd_price) : (op_price < rd_price);
    status.ins_ok      = (act_cnt < CW'(BOOK_DEPTH)) || (idx < act_cnt);
    status.shift_more  = (k > idx);
    status.del_more    = ((CW + 1)'(idx) + (CW + 1)'(1)) < (CW + 1)'(act_cnt);
    status.walk_more   = (idx < act_cnt) && (remaining != '0);
    status.filled_zero = (remaining == op_qty);
    status.slip_needed = (ref_price != '0) && (v_full != '0);
    status.div_busy    = div_busy;
    status.out_free    = !m_tvalid || m_tready;
  end

  // store port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_idx  = idx;
    we      = 1'b0;
    wr_idx  = idx;
    wr_data = rdata;
    case (op)
      DP_SCAN_RD: rd_en = 1'b1;
      DP_WALK_RD: rd_en = 1'b1;
      DP_SHIFT_RD: begin
        rd_en  = 1'b1;
        rd_idx = k - CW'(1);
      end
      DP_SHIFT_WR: begin
        we     = 1'b1;
        wr_idx = k;
      end
      DP_DEL_RD: begin
        rd_en  = 1'b1;
        rd_idx = idx + CW'(1);
      end
      DP_DEL_WR: we = 1'b1;
      DP_OVERWRITE, DP_PUT_NEW: begin
        we      = 1'b1;
        wr_data = {op_price, op_qty};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[{act_side, wr_idx[AW-1:0]}] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[{act_side, rd_idx[AW-1:0]}];
    end
  end

  // copy of each side's top entry
  always_ff @(posedge clk) begin
    if (we && (wr_idx == '0)) begin
      best_p[act_side] <= wr_data[63:32];
      best_q[act_side] <= wr_data[31:0];
    end
  end

  // shared divider: vwap then slippage
  assign div_start = (op == DP_VDIV_START) || (op == DP_SDIV_START);
  assign div_long  = (op == DP_VDIV_START);
  assign div_num   = div_long ? total : diff100;
  assign div_den   = div_long ? filled_now : ref_price;

  plob_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .long_run (div_long),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // slippage magnitude clamp
  always_comb begin
    if (neg) begin
      slip_mag = (div_q > SLIP_NEG_MAG) ? SLIP_NEG_MAG : div_q;
      slip_mag = 64'd0 - slip_mag;
    end else begin
      slip_mag = (div_q > SLIP_POS_MAX) ? SLIP_POS_MAX : div_q;
    end
  end

  // control state: counts, sequence, register, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt[0]    <= '0;
      cnt[1]    <= '0;
      seq       <= '0;
      depth_cfg <= MAX_DEPTH_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        depth_cfg <= cfg_wr_data;
      end
      case (op)
        DP_CLEAR: begin
          cnt[0] <= '0;
          cnt[1] <= '0;
          seq    <= '0;
        end
        DP_INS_SETUP: begin
          if (act_cnt < CW'(BOOK_DEPTH)) begin
            cnt[act_side] <= act_cnt + CW'(1);
          end
        end
        DP_DEL_END: cnt[act_side] <= act_cnt - CW'(1);
        DP_FINISH_MOD: begin
          seq <= seq + 64'd1;
          if (LW'(cnt[0]) > lim) begin
            cnt[0] <= CW'(lim);
          end
          if (LW'(cnt[1]) > lim) begin
            cnt[1] <= CW'(lim);
          end
        end
        default: begin
          seq <= seq;
        end
      endcase
      if (op == DP_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      DP_LOAD: begin
        op_cmd    <= s_tuser[2:0];
        op_side   <= s_tuser[3];
        op_price  <= s_tdata[31:0];
        op_qty    <= s_tdata[63:32];
        remaining <= s_tdata[63:32];
        idx       <= '0;
        total     <= '0;
        lvl       <= '0;
        filled_r  <= '0;
        vwap_r    <= '0;
        v_full    <= '0;
        slip_r    <= '0;
      end
      DP_SCAN_NEXT: idx <= idx + CW'(1);
      DP_INS_SETUP: k <= (act_cnt < CW'(BOOK_DEPTH)) ? act_cnt : act_cnt - CW'(1);
      DP_SHIFT_WR:  k <= k - CW'(1);
      DP_DEL_WR:    idx <= idx + CW'(1);
      DP_QUERY_HIT: lvl <= rd_qty;
      DP_WALK_MUL: begin
        prod      <= rd_price * fill;
        remaining <= remaining - fill;
        idx       <= idx + CW'(1);
      end
      DP_WALK_ACC:   total <= total + prod;
      DP_VDIV_START: filled_r <= filled_now;
      DP_VDIV_END: begin
        v_full <= div_q;
        vwap_r <= (div_q > VWAP_MAX) ? VWAP_MAX[47:0] : div_q[47:0];
      end
      DP_SLIP_PREP: begin
        if (is_bid) begin
          neg  <= v_full < rfix;
          diff <= (v_full < rfix) ? rfix - v_full : v_full - rfix;
        end else begin
          neg  <= rfix < v_full;
          diff <= (rfix < v_full) ? v_full - rfix : rfix - v_full;
        end
      end
      DP_SDIV_END: slip_r <= slip_mag[40:0];
      default: begin
        idx <= idx;
      end
    endcase
  end

  // result word
  assign bid_lv_w = LW'(cnt[0]);
  assign ask_lv_w = LW'(cnt[1]);

  always_ff @(posedge clk) begin
    if (op == DP_OUT) begin
      m_tdata <= {1'b0, slip_r, vwap_r, filled_r, lvl, seq,
                  ask_lv_w[6:0], bid_lv_w[6:0],
                  (cnt[1] != '0) ? best_q[1] : 32'd0,
                  (cnt[1] != '0) ? best_p[1] : 32'd0,
                  (cnt[0] != '0) ? best_q[0] : 32'd0,
                  (cnt[0] != '0) ? best_p[0] : 32'd0};
    end
  end

`ifndef ASSERT_OFF
  // writes stay inside the side's level range
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (wr_idx < CW'(BOOK_DEPTH)))
    else $error("level write beyond book depth");

  // clear empties both sides and restarts the sequence
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (op == DP_CLEAR) |=> ((cnt[0] == '0) && (cnt[1] == '0) && (seq == '0)))
    else $error("clear left state behind");

  // each book change advances the sequence by exactly one
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    (op == DP_FINISH_MOD) |=> (seq == $past(seq) + 64'd1))
    else $error("sequence count did not step");
`endif

endmodule

[bench/tb.sv]
module tb;
  import plob_pkg::*;

  // codes the package leaves unnamed
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int LEVELS = DEF_BOOK_DEPTH;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [63:0] MASK41 = 64'h0000_01FF_FFFF_FFFF;

  // last field sits in the lowest bits, as on m_tdata
  typedef struct packed {
    logic [40:0] slip;
    logic [47:0] vwap;
    logic [31:0] fill_qty;
    logic [31:0] lvl_qty;
    logic [63:0] upd_cnt;
    logic [6:0]  ask_lvls;
    logic [6:0]  bid_lvls;
    logic [31:0] ask_qty;
    logic [31:0] ask_px;
    logic [31:0] bid_qty;
    logic [31:0] bid_px;
  } snapshot_t;

  logic clk;
  logic rst;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic s_tvalid;
  logic s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready;
  logic cfg_wr_en;
  logic [6:0] cfg_wr_data;

  // book mirror: index 0 is the bid side, 1 the ask side, best level first
  logic [31:0] lvl_px[2][LEVELS];
  logic [31:0] lvl_qt[2][LEVELS];
  int lvl_cnt[2];
  logic [63:0] seq_cnt;
  int depth_reg;

  snapshot_t snap_q[$];
  int mismatches;
  int idle_cycles;
  bit gaps_on;
  int hold_left;
  int stall_left;

  price_level_order_book_core i_dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit ranks_higher(int sd, logic [31:0] a, logic [31:0] b);
    return (sd == 0) ? (a > b) : (a < b);
  endfunction

  function automatic int find_level(int sd, logic [31:0] px);
    for (int i = 0; i < lvl_cnt[sd]; i++)
      if (lvl_px[sd][i] == px) return i;
    return lvl_cnt[sd];
  endfunction

  function automatic void put_level(int sd, logic [31:0] px, logic [31:0] qt);
    int idx;
    int pos;
    int k;
    idx = find_level(sd, px);
    if (idx < lvl_cnt[sd]) begin
      lvl_qt[sd][idx] = qt;
      return;
    end
    pos = 0;
    while (pos < lvl_cnt[sd] && !ranks_higher(sd, px, lvl_px[sd][pos])) pos++;
    if (lvl_cnt[sd] < LEVELS) begin
      k = lvl_cnt[sd];
      lvl_cnt[sd]++;
    end else if (pos < lvl_cnt[sd]) begin
      k = lvl_cnt[sd] - 1;
    end else begin
      // new level would be the worst of a full side
      return;
    end
    for (; k > pos; k--) begin
      lvl_px[sd][k] = lvl_px[sd][k-1];
      lvl_qt[sd][k] = lvl_qt[sd][k-1];
    end
    lvl_px[sd][pos] = px;
    lvl_qt[sd][pos] = qt;
  endfunction

  function automatic void drop_level(int sd, logic [31:0] px);
    int idx;
    idx = find_level(sd, px);
    if (idx < lvl_cnt[sd]) begin
      for (int i = idx; i + 1 < lvl_cnt[sd]; i++) begin
        lvl_px[sd][i] = lvl_px[sd][i+1];
        lvl_qt[sd][i] = lvl_qt[sd][i+1];
      end
      lvl_cnt[sd]--;
    end
  endfunction

  // apply one command to the mirror and return the snapshot it yields
  function automatic snapshot_t book_apply(logic [2:0] cmd, logic sd_bit,
                                           logic [31:0] px, logic [31:0] qt);
    snapshot_t r;
    int sd;
    int w;
    int lim;
    int idx;
    logic [63:0] rem, total, fl, v, q, rm, f, refp, rfix, diff, mag;
    bit neg;
    sd = sd_bit;
    r = '0;
    case (cmd)
      CMD_ADD, CMD_UPDATE, CMD_DELETE: begin
        if (cmd == CMD_ADD || (cmd == CMD_UPDATE && qt != 0)) put_level(sd, px, qt);
        else drop_level(sd, px);
        seq_cnt++;
        lim = depth_reg < LEVELS ? depth_reg : LEVELS;
        for (int s = 0; s < 2; s++)
          if (lvl_cnt[s] > lim) lvl_cnt[s] = lim;
      end
      CMD_CLEAR: begin
        lvl_cnt[0] = 0;
        lvl_cnt[1] = 0;
        seq_cnt = '0;
      end
      CMD_QUERY: begin
        idx = find_level(sd, px);
        if (idx < lvl_cnt[sd]) r.lvl_qty = lvl_qt[sd][idx];
      end
      CMD_VWAP: begin
        // buy walks the asks, sell walks the bids; 64-bit wrapping sums
        w = 1 - sd;
        rem = qt;
        total = '0;
        for (int i = 0; i < lvl_cnt[w] && rem != 0; i++) begin
          fl = (lvl_qt[w][i] < rem) ? 64'(lvl_qt[w][i]) : rem;
          total += 64'(lvl_px[w][i]) * fl;
          rem -= fl;
        end
        fl = 64'(qt) - rem;
        v = '0;
        if (fl != 0) begin
          q = total / fl;
          rm = total % fl;
          f = '0;
          for (int b = 0; b < DEF_FRAC_BITS; b++) begin
            rm = rm << 1;
            f = f << 1;
            if (rm >= fl) begin
              rm -= fl;
              f[0] = 1'b1;
            end
          end
          v = (q << DEF_FRAC_BITS) | f;
        end
        r.fill_qty = fl[31:0];
        r.vwap = (v > VWAP_MAX) ? VWAP_MAX[47:0] : v[47:0];
        refp = (lvl_cnt[w] != 0) ? 64'(lvl_px[w][0]) : 64'd0;
        if (refp != 0 && v != 0) begin
          rfix = refp << DEF_FRAC_BITS;
          if (sd == 0) neg = v < rfix;
          else neg = rfix < v;
          diff = (v > rfix) ? v - rfix : rfix - v;
          mag = diff * 64'd100 / refp;
          if (neg) begin
            if (mag > SLIP_NEG_MAG) mag = SLIP_NEG_MAG;
            mag = (64'd0 - mag) & MASK41;
          end else if (mag > SLIP_POS_MAX) begin
            mag = SLIP_POS_MAX;
          end
          r.slip = mag[40:0];
        end
      end
      default: ;
    endcase
    if (lvl_cnt[0] != 0) begin
      r.bid_px = lvl_px[0][0];
      r.bid_qty = lvl_qt[0][0];
    end
    if (lvl_cnt[1] != 0) begin
      r.ask_px = lvl_px[1][0];
      r.ask_qty = lvl_qt[1][0];
    end
    r.bid_lvls = 7'(lvl_cnt[0]);
    r.ask_lvls = 7'(lvl_cnt[1]);
    r.upd_cnt = seq_cnt;
    return r;
  endfunction

  // offer one command word; valid stays high for a following word
  task automatic send_word(logic [2:0] cmd, logic sd, logic [31:0] px, logic [31:0] qt);
    int gap;
    snapshot_t exp_snap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {qt, px};
    s_tuser <= {sd, cmd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp_snap = book_apply(cmd, sd, px, qt);
    snap_q = {snap_q, exp_snap};
  endtask

  // drain everything, then let the core settle before a register write
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (snap_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_depth(int d);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 7'(d);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    depth_reg = d;
  endtask

  // random word, mostly book traffic around two overlapping price bands
  task automatic send_random();
    logic [2:0] cmd;
    logic sd;
    logic [31:0] px, qt;
    int r;
    r = $urandom_range(0, 99);
    sd = 1'($urandom_range(0, 1));
    if (r < 40) cmd = CMD_ADD;
    else if (r < 55) cmd = CMD_UPDATE;
    else if (r < 67) cmd = CMD_DELETE;
    else if (r < 77) cmd = CMD_QUERY;
    else if (r < 93) cmd = CMD_VWAP;
    else if (r < 95) cmd = CMD_CLEAR;
    else cmd = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 40 && lvl_cnt[sd] > 0)
      px = lvl_px[sd][$urandom_range(0, lvl_cnt[sd] - 1)];
    else if (r < 88)
      px = (sd == 0) ? 1000 + $urandom_range(0, 79) : 1040 + $urandom_range(0, 79);
    else if (r < 96)
      px = $urandom;
    else
      px = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    r = $urandom_range(0, 99);
    if (r < 10) qt = 0;
    else if (r < 75) qt = $urandom_range(1, (cmd == CMD_VWAP) ? 6000 : 1000);
    else if (r < 95) qt = $urandom;
    else qt = 32'hFFFF_FFFF;
    send_word(cmd, sd, px, qt);
  endtask

  // result check
  always @(posedge clk) begin
    snapshot_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[358:0];
      if (snap_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = snap_q.pop_front();
        if (got.bid_px !== want.bid_px || got.bid_qty !== want.bid_qty ||
            got.ask_px !== want.ask_px || got.ask_qty !== want.ask_qty ||
            got.bid_lvls !== want.bid_lvls || got.ask_lvls !== want.ask_lvls ||
            got.upd_cnt !== want.upd_cnt || got.lvl_qty !== want.lvl_qty ||
            got.fill_qty !== want.fill_qty || got.vwap !== want.vwap ||
            got.slip !== want.slip) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("got:  bid %0d/%0d ask %0d/%0d lv %0d/%0d upd %0d lq %0d fq %0d",
                     got.bid_px, got.bid_qty, got.ask_px, got.ask_qty, got.bid_lvls,
                     got.ask_lvls, got.upd_cnt, got.lvl_qty, got.fill_qty);
            $display("      vw %h sl %h", got.vwap, got.slip);
            $display("want: bid %0d/%0d ask %0d/%0d lv %0d/%0d upd %0d lq %0d fq %0d",
                     want.bid_px, want.bid_qty, want.ask_px, want.ask_qty, want.bid_lvls,
                     want.ask_lvls, want.upd_cnt, want.lvl_qty, want.fill_qty);
            $display("      vw %h sl %h", want.vwap, want.slip);
          end
        end
      end
    end
  end

  // result receiver: long hold, random stall bursts, otherwise ready
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(CMD_ADD, 1'b0, 32'd100, 32'd10);
    send_word(CMD_ADD, 1'b0, 32'd105, 32'd0);
    send_word(CMD_ADD, 1'b0, 32'd105, 32'hFFFF_FFFF);
    send_word(CMD_ADD, 1'b1, 32'd110, 32'd7);
    send_word(CMD_ADD, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_ADD, 1'b0, 32'd0, 32'd3);
    send_word(CMD_UPDATE, 1'b1, 32'd108, 32'd4);
    send_word(CMD_UPDATE, 1'b0, 32'd100, 32'd0);
    send_word(CMD_DELETE, 1'b1, 32'd999, 32'd1);
    send_word(CMD_QUERY, 1'b0, 32'd105, 32'd0);
    send_word(CMD_QUERY, 1'b1, 32'd12345, 32'd0);
    send_word(CMD_VWAP, 1'b0, 32'd0, 32'd9);
    send_word(CMD_VWAP, 1'b1, 32'd0, 32'hFFFF_FFFF);
    send_word(CMD_VWAP, 1'b0, 32'd0, 32'd0);
    send_word(CMD_VWAP, 1'b0, 32'd0, 32'hFFFF_FFFF);
    send_word(CMD_DELETE, 1'b1, 32'd108, 32'd0);
    send_word(CMD_SPARE6, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_SPARE7, 1'b0, 32'd0, 32'd0);
    send_word(CMD_CLEAR, 1'b0, 32'd0, 32'd0);
    send_word(CMD_VWAP, 1'b1, 32'd0, 32'd5);
    send_word(CMD_QUERY, 1'b0, 32'd0, 32'd0);
  endtask

  // overfill both sides, inserting new worst and new best levels
  task automatic test_full_side();
    set_depth(127);
    for (int i = 0; i < 70; i++) begin
      send_word(CMD_ADD, 1'b0, 32'd5000 - 32'(i), 32'(i + 1));
      send_word(CMD_ADD, 1'b1, 32'd6000 + 32'(i * 3), 32'(i + 2));
    end
    send_word(CMD_ADD, 1'b0, 32'd6000, 32'd8);
    send_word(CMD_ADD, 1'b1, 32'd5500, 32'd8);
    send_word(CMD_VWAP, 1'b0, 32'd0, 32'hFFFF_FFFF);
    send_word(CMD_VWAP, 1'b1, 32'd0, 32'd1000);
  endtask

  task automatic test_depths();
    int depths[6] = '{1, 0, 7, 64, 32, 127};
    foreach (depths[d]) begin
      set_depth(depths[d]);
      repeat (170) send_random();
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    wait_idle();
    hold_left = 300;
    repeat (25) send_random();
  endtask

  task automatic test_steady();
    wait_idle();
    gaps_on = 1'b0;
    repeat (100) send_random();
  endtask

  initial begin
    rst = 1'b1;
    s_tdata = '0;
    s_tuser = '0;
    s_tvalid = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    lvl_cnt[0] = 0;
    lvl_cnt[1] = 0;
    seq_cnt = '0;
    depth_reg = MAX_DEPTH_RESET;
    mismatches = 0;
    idle_cycles = 0;
    gaps_on = 1'b1;
    hold_left = 0;
    stall_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_side();
    test_depths();
    test_backpressure();
    test_steady();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && snap_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[price_level_order_book_core.f]
rtl/plob_pkg.sv
rtl/plob_divider.sv
rtl/plob_ctrl.sv
rtl/plob_datapath.sv
rtl/price_level_order_book_core.sv
bench/tb.sv
